// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that cond is never true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_HOLDS(label, clk, rst_n, !(cond), msg)

`endif

// ----- hdl/gsm_pkg.sv -----
// ---------------------------------------------------------------------------
// gsm_pkg
// Types and fixed constants of the golden-section minimizer.
// ---------------------------------------------------------------------------
package gsm_pkg;

	localparam int DATA_W = 32;
	localparam int TOL_W  = 29;
	localparam int STEP_W = 7;
	localparam int GOLD_W = 32;

	// Golden ratio parts as unsigned Q0.32
	localparam logic [GOLD_W-1:0] GOLD_BIG   = 32'd2654435769;
	localparam logic [GOLD_W-1:0] GOLD_SMALL = 32'd1640531527;

	localparam logic [TOL_W-1:0] TOL_RESET = 29'd268435;

	typedef enum logic [3:0] {
		S_IDLE,
		S_GOLD_N,
		S_GOLD_F,
		S_SQ_N,
		S_X2_N,
		S_X4_N,
		S_SQ_F,
		S_X2_F,
		S_X4_F,
		S_UPDATE,
		S_CHECK,
		S_DONE
	} state_t;

endpackage

// ----- hdl/gsm_mul.sv -----
// ---------------------------------------------------------------------------
// gsm_mul
// Shared unsigned multiplier with a registered product.
// ---------------------------------------------------------------------------
module gsm_mul #(
	parameter int W = 35
) (
	input  logic           clk,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] p
);

	always_ff @(posedge clk) begin
		p <= (2*W)'(a) * (2*W)'(b);
	end

endmodule

// ----- hdl/golden_section_minimizer.sv -----
// One request at a time: a request runs 1 to MAX_ITER iterations, each with eight
// products on the one shared multiplier (two golden parts, three per objective value),
// an update and a check. in_stall is high until the result is in the output register,
// which holds it while the next one runs.
// Reset: arst_n clears control state and sets tolerance to 268435.
// ---------------------------------------------------------------------------
// golden_section_minimizer
// Golden-section search for the minimum of (x-7)^2 + x^4 over a start interval.
// ---------------------------------------------------------------------------
module golden_section_minimizer #(
	parameter int FRAC_BITS = 28,
	parameter int MAX_ITER  = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [gsm_pkg::TOL_W-1:0]       cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [gsm_pkg::DATA_W-1:0] start_low,
	input  logic signed [gsm_pkg::DATA_W-1:0] start_high,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [gsm_pkg::DATA_W-1:0] final_low,
	output logic signed [gsm_pkg::DATA_W-1:0] final_high,
	output logic                            hit_limit
);

	import gsm_pkg::*;

	`include "assert_macros.svh"

	localparam int POS_W = FRAC_BITS + 4;
	localparam int MW    = (FRAC_BITS + 7 > GOLD_W) ? FRAC_BITS + 7 : GOLD_W;
	localparam int OBJ_W = FRAC_BITS + 14;
	localparam int CMP_W = (POS_W > TOL_W) ? POS_W : TOL_W;

	localparam logic signed [DATA_W:0]  IN_MIN = -(33'sd1 <<< (POS_W - 1));
	localparam logic signed [DATA_W:0]  IN_MAX = (33'sd1 <<< (POS_W - 1)) - 33'sd1;
	localparam logic signed [POS_W+1:0] PT_MIN = -((POS_W+2)'(1) <<< (POS_W - 1));
	localparam logic signed [POS_W+1:0] PT_MAX = ((POS_W+2)'(1) <<< (POS_W - 1)) - 1;
	localparam logic signed [POS_W:0]   SEVEN  = (POS_W+1)'(7) <<< FRAC_BITS;
	localparam logic [STEP_W-1:0]       STEP_CAP = STEP_W'(MAX_ITER);

	function automatic logic signed [POS_W-1:0] clamp_in(logic signed [DATA_W-1:0] v);
		logic signed [DATA_W:0] e;
		e = (DATA_W+1)'(v);
		if (e < IN_MIN)
			return POS_W'(IN_MIN);
		else if (e > IN_MAX)
			return POS_W'(IN_MAX);
		else
			return POS_W'(e);
	endfunction

	function automatic logic signed [POS_W-1:0] clamp_pt(logic signed [POS_W+1:0] v);
		if (v < PT_MIN)
			return POS_W'(PT_MIN);
		else if (v > PT_MAX)
			return POS_W'(PT_MAX);
		else
			return POS_W'(v);
	endfunction

	state_t state_q, state_d;

	logic [TOL_W-1:0]        tol_q;
	logic signed [POS_W-1:0] left_q, right_q, near_q, far_q;
	logic [STEP_W-1:0]       step_q;
	logic [OBJ_W-1:0]        obj_n_q;
	logic [FRAC_BITS+7:0]    sq_q;
	logic                    hit_q;

	logic                    out_valid_q;
	logic signed [DATA_W-1:0] final_low_q, final_high_q;
	logic                    hit_limit_q;

	logic [MW-1:0]           mul_a, mul_b;
	logic [2*MW-1:0]         mul_p;

	logic signed [POS_W:0]   w;
	logic [POS_W-1:0]        w_mag;
	logic signed [POS_W:0]   g_part;
	logic signed [POS_W-1:0] g_point;
	logic signed [POS_W-1:0] x_sel;
	logic signed [POS_W:0]   d_sgn;
	logic [POS_W-1:0]        d_mag;
	logic [POS_W-1:0]        ax_mag;
	logic [FRAC_BITS+6:0]    x2;
	logic [OBJ_W-1:0]        obj_cur;
	logic                    near_wins;
	logic signed [POS_W:0]   gap_l_sgn, gap_r_sgn;
	logic [POS_W-1:0]        gap_l, gap_r;
	logic                    gap_met;
	logic                    out_free;

	gsm_mul #(
		.W (MW)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// Datapath around the shared multiplier
	always_comb begin
		w       = (POS_W+1)'(right_q) - (POS_W+1)'(left_q);
		w_mag   = (w < 0) ? POS_W'(-w) : POS_W'(w);
		g_part  = $signed({1'b0, mul_p[POS_W+GOLD_W-1:GOLD_W]});
		if (w < 0)
			g_part = -g_part;
		g_point = clamp_pt((POS_W+2)'(left_q) + (POS_W+2)'(g_part));

		x_sel  = (state_q == S_SQ_N || state_q == S_X2_N) ? near_q : far_q;
		d_sgn  = (POS_W+1)'(x_sel) - SEVEN;
		d_mag  = (d_sgn < 0) ? POS_W'(-d_sgn) : POS_W'(d_sgn);
		ax_mag = (x_sel < 0) ? POS_W'(-((POS_W+1)'(x_sel))) : POS_W'(x_sel);
		x2     = mul_p[2*FRAC_BITS+6:FRAC_BITS];

		obj_cur   = OBJ_W'(sq_q) + OBJ_W'(mul_p[2*FRAC_BITS+12:FRAC_BITS]);
		near_wins = obj_n_q < obj_cur;

		gap_l_sgn = (POS_W+1)'(left_q) - (POS_W+1)'(far_q);
		gap_r_sgn = (POS_W+1)'(near_q) - (POS_W+1)'(right_q);
		gap_l     = (gap_l_sgn < 0) ? POS_W'(-gap_l_sgn) : POS_W'(gap_l_sgn);
		gap_r     = (gap_r_sgn < 0) ? POS_W'(-gap_r_sgn) : POS_W'(gap_r_sgn);
		gap_met   = (CMP_W'(gap_l) <= CMP_W'(tol_q)) || (CMP_W'(gap_r) <= CMP_W'(tol_q));

		out_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and multiplier operands
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_GOLD_N;
			end
			S_GOLD_N: begin
				mul_a   = MW'(w_mag);
				mul_b   = MW'(GOLD_SMALL);
				state_d = S_GOLD_F;
			end
			S_GOLD_F: begin
				mul_a   = MW'(w_mag);
				mul_b   = MW'(GOLD_BIG);
				state_d = S_SQ_N;
			end
			S_SQ_N, S_SQ_F: begin
				mul_a   = MW'(d_mag);
				mul_b   = MW'(d_mag);
				state_d = (state_q == S_SQ_N) ? S_X2_N : S_X2_F;
			end
			S_X2_N, S_X2_F: begin
				mul_a   = MW'(ax_mag);
				mul_b   = MW'(ax_mag);
				state_d = (state_q == S_X2_N) ? S_X4_N : S_X4_F;
			end
			S_X4_N, S_X4_F: begin
				mul_a   = MW'(x2);
				mul_b   = MW'(x2);
				state_d = (state_q == S_X4_N) ? S_SQ_F : S_UPDATE;
			end
			S_UPDATE: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (gap_met || step_q >= STEP_CAP)
					state_d = S_DONE;
				else
					state_d = S_GOLD_N;
			end
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q  <= TOL_RESET;
			step_q <= '0;
			hit_q  <= 1'b0;
		end else begin
			if (cfg_we)
				tol_q <= cfg_wdata;
			if (state_q == S_IDLE && in_valid)
				step_q <= '0;
			else if (state_q == S_UPDATE)
				step_q <= step_q + STEP_W'(1);
			if (state_q == S_CHECK)
				hit_q <= !gap_met;
		end
	end

	// Search registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					left_q  <= clamp_in(start_low);
					right_q <= clamp_in(start_high);
				end
			end
			S_GOLD_F: near_q <= g_point;
			S_SQ_N:   far_q  <= g_point;
			S_X2_N,
			S_X2_F:   sq_q   <= mul_p[2*FRAC_BITS+7:FRAC_BITS];
			S_SQ_F:   obj_n_q <= obj_cur;
			S_UPDATE: begin
				// Keep the better interior point, drop the far side
				if (near_wins) begin
					right_q <= far_q;
					far_q   <= near_q;
				end else begin
					left_q <= near_q;
					near_q <= far_q;
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			final_low_q  <= DATA_W'(left_q);
			final_high_q <= DATA_W'(right_q);
			hit_limit_q  <= hit_q;
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign final_low  = final_low_q;
	assign final_high = final_high_q;
	assign hit_limit  = hit_limit_q;

	`ASSERT_NEVER(a_step_cap, clk, arst_n, step_q > STEP_CAP, "iteration count passed the cap")
	`ASSERT_HOLDS(a_limit_count, clk, arst_n, (state_q == S_DONE && hit_q) |-> (step_q == STEP_CAP), "limit flag without reaching the cap")
	`ASSERT_HOLDS(a_result_src, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result posted outside the finish step")

endmodule
